@@ rtl/core/gqa_pkg.sv @@
// ----------------------------------------------------------------------------
// gqa_pkg
// Types and constants shared by the group quota admission block.
// ----------------------------------------------------------------------------
package gqa_pkg;

    localparam int ELEM_W    = 8;
    localparam int MASK_W    = 8;
    localparam int CNT_W     = 9;
    localparam int NUM_LIMIT = 8;
    localparam int LIM_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX   = 9'd511;
    localparam logic [CNT_W-1:0] LIMIT_RST = 9'd256;

    typedef enum logic [2:0] {
        ACT_CAN_ADD   = 3'd0,
        ACT_CAN_SWAP  = 3'd1,
        ACT_ADD       = 3'd2,
        ACT_REMOVE    = 3'd3,
        ACT_CLEAR     = 3'd4,
        ACT_LOAD_MASK = 3'd5,
        ACT_IS_MEMBER = 3'd6,
        ACT_NOP       = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ALREADY     = 2'd1,
        ST_NOT_CHOSEN  = 2'd2,
        ST_LOAD_REFUSE = 2'd3
    } t_status;

    typedef struct packed {
        t_action            action;
        logic [ELEM_W-1:0]  element;
        logic [ELEM_W-1:0]  other_element;
        logic [MASK_W-1:0]  group_mask;
    } t_req;

    // counter update request, already qualified by the committing transaction
    typedef struct packed {
        logic              inc;
        logic              dec;
        logic              clr;
        logic [MASK_W-1:0] mask;
    } t_cnt_cmd;

    typedef struct packed {
        logic [MASK_W-1:0] full;       // count has reached limit, current state
        logic              in_limits;  // all counts within limits after update
    } t_cnt_stat;

endpackage

@@ rtl/core/gqa_if.sv @@
// ----------------------------------------------------------------------------
// gqa_if
// Valid/ready channel interfaces: request, response and limit write port.
// ----------------------------------------------------------------------------
interface gqa_req_if import gqa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [ELEM_W-1:0] element;
    logic [ELEM_W-1:0] other_element;
    logic [MASK_W-1:0] group_mask;

    modport source (output valid, action, element, other_element, group_mask,
                    input ready);
    modport sink   (input valid, action, element, other_element, group_mask,
                    output ready);
endinterface

interface gqa_rsp_if import gqa_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       answer;
    logic [1:0] status;
    logic       all_within_limits;

    modport source (output valid, answer, status, all_within_limits, input ready);
    modport sink   (input valid, answer, status, all_within_limits, output ready);
endinterface

interface gqa_cfg_if import gqa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LIM_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/gqa_mask_ram.sv @@
// ----------------------------------------------------------------------------
// gqa_mask_ram
// Membership mask store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gqa_mask_ram
    import gqa_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [MASK_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [MASK_W-1:0] o_rdata_a,
    output logic [MASK_W-1:0] o_rdata_b
);

    logic [MASK_W-1:0] r_mem [DEPTH];
    logic [MASK_W-1:0] r_rdata_a;
    logic [MASK_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/core/gqa_counters.sv @@
// ----------------------------------------------------------------------------
// gqa_counters
// Per-group occupancy counters, limit registers and the limit compares.
// ----------------------------------------------------------------------------
module gqa_counters
    import gqa_pkg::*;
#(
    parameter int NUM_GROUPS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gqa_cfg_if.sink   i_cfg,
    input  t_cnt_cmd  i_cmd,
    output t_cnt_stat o_stat
);

    logic [CNT_W-1:0] r_limit [NUM_LIMIT];
    logic [CNT_W-1:0] r_cnt   [NUM_GROUPS];
    logic [CNT_W-1:0] n_cnt   [NUM_GROUPS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LIMIT; i++) begin
                r_limit[i] <= LIMIT_RST;
            end
        end else if (i_cfg.valid) begin
            r_limit[i_cfg.index] <= i_cfg.data;
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_cnt[g] = r_cnt[g];
            if (i_cmd.clr) begin
                n_cnt[g] = '0;
            end else if (i_cmd.inc && i_cmd.mask[g] && r_cnt[g] != CNT_MAX) begin
                n_cnt[g] = r_cnt[g] + 1'b1;
            end else if (i_cmd.dec && i_cmd.mask[g] && r_cnt[g] != '0) begin
                n_cnt[g] = r_cnt[g] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_cnt[g] <= '0;
            end
        end else begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_cnt[g] <= n_cnt[g];
            end
        end
    end

    // full uses the counts before the update, in_limits the counts after it
    always_comb begin
        o_stat.full      = '0;
        o_stat.in_limits = 1'b1;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            o_stat.full[g] = (r_cnt[g] >= r_limit[g]);
            if (n_cnt[g] > r_limit[g]) begin
                o_stat.in_limits = 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/group_quota_admission.sv @@
// ----------------------------------------------------------------------------
// group_quota_admission
// Admission oracle for a set of elements under per-group occupancy limits.
// ----------------------------------------------------------------------------
// Channels: i_req carries one action per transaction (query, add, remove,
// clear, mask load, membership test); o_rsp returns exactly one result per
// request, in order. i_cfg writes the group limit registers, index 0..7,
// and is always ready; write it only while no request is in flight.
// Timing: an accepted request passes the mask read register, then the
// result register. Throughput: one request per cycle while o_rsp is not
// held off; a mask loaded by one request is forwarded to the next.
// Reset: the set is empty, all counters are zero, every mask reads as
// empty and every limit is 256. No clearing pass, the block is ready as
// soon as reset is released.
// Stall: when o_rsp is held off the result register holds, the request in
// the mask read stage waits, and i_req takes one more transaction only
// if that stage is empty.
// ----------------------------------------------------------------------------
module group_quota_admission
    import gqa_pkg::*;
#(
    parameter int NUM_GROUPS   = 8,
    parameter int NUM_ELEMENTS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gqa_req_if.sink   i_req,
    gqa_rsp_if.source o_rsp,
    gqa_cfg_if.sink   i_cfg
);

    localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int XW = ((AW > ELEM_W) ? AW : ELEM_W) + 1;
    localparam int CW = $clog2(NUM_ELEMENTS + 1);
    localparam logic [MASK_W-1:0] GROUP_BITS = MASK_W'((1 << NUM_GROUPS) - 1);

    // pipeline control
    logic r_s1_valid;
    t_req r_s1;
    logic r_out_valid;
    logic adv;
    logic in_ready;
    logic accept;
    logic fire;

    assign adv      = !r_out_valid || o_rsp.ready;
    assign in_ready = !r_s1_valid || adv;
    assign accept   = i_req.valid && in_ready;
    assign fire     = r_s1_valid && adv;
    assign i_req.ready = in_ready;

    // state
    logic [NUM_ELEMENTS-1:0] r_chosen;
    logic [NUM_ELEMENTS-1:0] r_written;
    logic [CW-1:0]           r_num_chosen;
    logic                    r_fwd_vld;
    logic [AW-1:0]           r_fwd_addr;
    logic [MASK_W-1:0]       r_fwd_data;

    // response register
    logic    r_answer;
    t_status r_status;
    logic    r_within;

    // element decode
    logic [XW-1:0]     e_ext, o_ext, in_e_ext, in_o_ext;
    logic [AW-1:0]     e_addr, o_addr;
    logic              e_in, o_in;
    logic              e_chosen, o_chosen;
    logic [MASK_W-1:0] ram_a, ram_b, raw_e, raw_o, mask_e, mask_o, full_e;

    assign in_e_ext = XW'(i_req.element);
    assign in_o_ext = XW'(i_req.other_element);
    assign e_ext    = XW'(r_s1.element);
    assign o_ext    = XW'(r_s1.other_element);
    assign e_addr   = e_ext[AW-1:0];
    assign o_addr   = o_ext[AW-1:0];
    assign e_in     = e_ext < XW'(NUM_ELEMENTS);
    assign o_in     = o_ext < XW'(NUM_ELEMENTS);
    assign e_chosen = e_in && r_chosen[e_addr];
    assign o_chosen = o_in && r_chosen[o_addr];

    // write memory / update next
    logic              mem_we;
    logic [MASK_W-1:0] mem_wdata;
    t_cnt_cmd          cnt_cmd;
    t_cnt_stat         cnt_stat;
    logic              n_answer;
    t_status           n_status;
    logic              set_flag, clr_flag, clr_all;

    gqa_mask_ram #(
        .DEPTH (NUM_ELEMENTS),
        .AW    (AW)
    ) u_mask_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (e_addr),
        .i_wdata   (mem_wdata),
        .i_re      (accept),
        .i_raddr_a (in_e_ext[AW-1:0]),
        .i_raddr_b (in_o_ext[AW-1:0]),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // the read that went with this request missed a write at the same edge
    assign raw_e  = (r_fwd_vld && r_fwd_addr == e_addr) ? r_fwd_data : ram_a;
    assign raw_o  = (r_fwd_vld && r_fwd_addr == o_addr) ? r_fwd_data : ram_b;
    assign mask_e = (e_in && r_written[e_addr]) ? raw_e : '0;
    assign mask_o = (o_in && r_written[o_addr]) ? raw_o : '0;
    assign full_e = cnt_stat.full & mask_e;
    assign mem_wdata = r_s1.group_mask & GROUP_BITS;

    always_comb begin
        n_answer     = 1'b0;
        n_status     = ST_OK;
        mem_we       = 1'b0;
        set_flag     = 1'b0;
        clr_flag     = 1'b0;
        clr_all      = 1'b0;
        cnt_cmd      = '0;
        cnt_cmd.mask = mask_e;
        unique case (r_s1.action)
            ACT_CAN_ADD: begin
                if (e_chosen) begin
                    n_status = ST_ALREADY;
                end else begin
                    n_answer = (full_e == '0);
                end
            end
            ACT_CAN_SWAP: begin
                if (e_chosen) begin
                    n_status = ST_ALREADY;
                end else if (!o_chosen) begin
                    n_status = ST_NOT_CHOSEN;
                end else begin
                    n_answer = ((full_e & ~mask_o) == '0);
                end
            end
            ACT_ADD: begin
                if (e_chosen) begin
                    n_status = ST_ALREADY;
                    n_answer = 1'b1;
                end else if (e_in) begin
                    set_flag    = fire;
                    cnt_cmd.inc = fire;
                    n_answer    = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (!e_chosen) begin
                    n_status = ST_NOT_CHOSEN;
                end else begin
                    clr_flag    = fire;
                    cnt_cmd.dec = fire;
                end
            end
            ACT_CLEAR: begin
                clr_all     = fire;
                cnt_cmd.clr = fire;
            end
            ACT_LOAD_MASK: begin
                if (r_num_chosen != '0) begin
                    n_status = ST_LOAD_REFUSE;
                end else if (e_in) begin
                    mem_we = fire;
                end
            end
            ACT_IS_MEMBER: begin
                n_answer = e_chosen;
            end
            ACT_NOP: begin
            end
            default: begin
            end
        endcase
    end

    gqa_counters #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_cmd   (cnt_cmd),
        .o_stat  (cnt_stat)
    );

    // request stage and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.action        <= t_action'(i_req.action);
            r_s1.element       <= i_req.element;
            r_s1.other_element <= i_req.other_element;
            r_s1.group_mask    <= i_req.group_mask;
        end
        if (fire) begin
            r_answer   <= n_answer;
            r_status   <= n_status;
            r_within   <= cnt_stat.in_limits;
            r_fwd_addr <= e_addr;
            r_fwd_data <= mem_wdata;
        end
    end

    // set membership and mask valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chosen     <= '0;
            r_written    <= '0;
            r_num_chosen <= '0;
            r_fwd_vld    <= 1'b0;
        end else begin
            if (fire) begin
                r_fwd_vld <= mem_we;
            end
            if (clr_all) begin
                r_chosen     <= '0;
                r_num_chosen <= '0;
            end else if (set_flag) begin
                r_chosen[e_addr] <= 1'b1;
                r_num_chosen     <= r_num_chosen + 1'b1;
            end else if (clr_flag) begin
                r_chosen[e_addr] <= 1'b0;
                r_num_chosen     <= r_num_chosen - 1'b1;
            end
            if (mem_we) begin
                r_written[e_addr] <= 1'b1;
            end
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.answer            = r_answer;
    assign o_rsp.status            = r_status;
    assign o_rsp.all_within_limits = r_within;

endmodule
